[rtl/pu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_pkg
// Shared widths, the double factorial table and controller/datapath links
// for the pairing unranker.
// ----------------------------------------------------------------------------
package pu_pkg;

  localparam int unsigned ITEM_LIMIT_DEF = 12;
  localparam int unsigned NUM_W          = 4;
  localparam int unsigned NIB_W          = 4;
  localparam int unsigned IDX_W          = 14;
  localparam int unsigned TOTAL_W        = 14;
  localparam int unsigned PAIR_SLOTS     = 11;
  localparam int unsigned PAIR_W         = PAIR_SLOTS * NIB_W;
  localparam int unsigned LIST_LEN       = 16;
  localparam int unsigned FULL_W         = 21;
  localparam int unsigned QBIT_W         = 2;
  localparam int unsigned SHIFT_W        = FULL_W + (1 << QBIT_W) - 1;

  typedef struct packed {
    logic              load;
    logic              div_step;
    logic [QBIT_W-1:0] div_bit;
    logic              pick;
  } pu_cmd_t;

  typedef struct packed {
    logic ok;
    logic last;
  } pu_status_t;

  // m!! for m in 0..15
  function automatic logic [FULL_W-1:0] dfact(input logic [NUM_W-1:0] m);
    logic [FULL_W-1:0] v;
    case (m)
      4'd0:    v = 21'd1;
      4'd1:    v = 21'd1;
      4'd2:    v = 21'd2;
      4'd3:    v = 21'd3;
      4'd4:    v = 21'd8;
      4'd5:    v = 21'd15;
      4'd6:    v = 21'd48;
      4'd7:    v = 21'd105;
      4'd8:    v = 21'd384;
      4'd9:    v = 21'd945;
      4'd10:   v = 21'd3840;
      4'd11:   v = 21'd10395;
      4'd12:   v = 21'd46080;
      4'd13:   v = 21'd135135;
      4'd14:   v = 21'd645120;
      4'd15:   v = 21'd2027025;
      default: v = 21'd1;
    endcase
    return v;
  endfunction

  // number of pairings of n elements, zero outside the supported range
  function automatic logic [FULL_W-1:0] total_full(input logic [NUM_W-1:0] n,
                                                   input int unsigned limit);
    logic [FULL_W-1:0] v;
    if (n < NUM_W'(2) || 32'(n) >= limit) begin
      v = '0;
    end else if (n[0]) begin
      v = dfact(n);
    end else begin
      v = dfact(n - NUM_W'(1));
    end
    return v;
  endfunction

endpackage

[rtl/pu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_ctrl
// Sequencer for the pairing unranker: load, four restoring divide steps per
// digit, element pick, result strobe.
// ----------------------------------------------------------------------------
module pu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pu_pkg::pu_status_t status_i,
  output pu_pkg::pu_cmd_t    cmd_o,
  output logic               busy_o,
  output logic               done_o
);
  import pu_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_PICK = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [QBIT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.div_bit = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cnt_d   = '1;
        state_d = status_i.ok ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_PICK;
        end else begin
          cnt_d = cnt_q - QBIT_W'(1);
        end
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        cnt_d      = '1;
        state_d    = status_i.last ? ST_DONE : ST_DIV;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

[rtl/pu_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_dpath
// Datapath of the pairing unranker: element count register, digit divider,
// ordered list of remaining elements and the slot registers.
// ----------------------------------------------------------------------------
module pu_dpath #(
  parameter int unsigned ITEM_LIMIT = pu_pkg::ITEM_LIMIT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pu_pkg::NUM_W-1:0]   cfg_wdata_i,
  input  logic [pu_pkg::IDX_W-1:0]   index_i,
  input  pu_pkg::pu_cmd_t            cmd_i,
  output pu_pkg::pu_status_t         status_o,
  output logic [pu_pkg::PAIR_W-1:0]  pairing_o,
  output logic [pu_pkg::TOTAL_W-1:0] total_o,
  output logic                       valid_res_o
);
  import pu_pkg::*;

  // divisor of a pair digit while r elements remain: (r-3)!!
  function automatic logic [FULL_W-1:0] sub_of(input logic [NUM_W-1:0] r);
    logic [FULL_W-1:0] v;
    if (r >= NUM_W'(3)) begin
      v = dfact(r - NUM_W'(3));
    end else begin
      v = FULL_W'(1);
    end
    return v;
  endfunction

  logic [NUM_W-1:0]   n_q;
  logic [IDX_W-1:0]   idx_q;
  logic [FULL_W-1:0]  sub_q;
  logic [NIB_W-1:0]   q_q;
  logic [NIB_W-1:0]   lst_q [LIST_LEN];
  logic [NUM_W-1:0]   rem_q;
  logic [NUM_W-1:0]   slot_q;
  logic               odd_q;
  logic [NIB_W-1:0]   pair_q [PAIR_SLOTS];
  logic [TOTAL_W-1:0] total_q;
  logic               valid_q;

  logic [FULL_W-1:0]  tot_full;
  logic               req_ok;
  logic [SHIFT_W-1:0] shifted;
  logic               ge;
  logic [NIB_W-1:0]   sel;
  logic [NIB_W-1:0]   picked;
  logic [NIB_W-1:0]   lst_d [LIST_LEN];
  logic [NIB_W-1:0]   pair_d [PAIR_SLOTS];
  logic [NUM_W-1:0]   rem_n;
  logic [NUM_W-1:0]   odd_slot;

  assign tot_full = total_full(n_q, ITEM_LIMIT);
  assign req_ok   = (tot_full != '0) && ({{(FULL_W-IDX_W){1'b0}}, index_i} < tot_full);

  // restoring divide step
  assign shifted = {{(SHIFT_W-FULL_W){1'b0}}, sub_q} << cmd_i.div_bit;
  assign ge      = ({{(SHIFT_W-IDX_W){1'b0}}, idx_q} >= shifted);

  // element picked by the digit
  assign sel      = odd_q ? q_q : q_q + NIB_W'(1);
  assign picked   = lst_q[sel];
  assign rem_n    = odd_q ? rem_q - NUM_W'(1) : rem_q - NUM_W'(2);
  assign odd_slot = n_q - NUM_W'(1);

  always_comb begin
    for (int i = 0; i < LIST_LEN; i++) begin
      if (NIB_W'(i) < q_q) begin
        lst_d[i] = odd_q ? lst_q[i] : lst_q[(i + 1 < LIST_LEN) ? i + 1 : LIST_LEN - 1];
      end else if (odd_q) begin
        lst_d[i] = lst_q[(i + 1 < LIST_LEN) ? i + 1 : LIST_LEN - 1];
      end else begin
        lst_d[i] = lst_q[(i + 2 < LIST_LEN) ? i + 2 : LIST_LEN - 1];
      end
    end
    for (int k = 0; k < PAIR_SLOTS; k++) begin
      pair_d[k] = pair_q[k];
      if (odd_q) begin
        if (odd_slot == NUM_W'(k)) begin
          pair_d[k] = picked;
        end
      end else if (slot_q == NUM_W'(k)) begin
        pair_d[k] = lst_q[0];
      end else if (slot_q + NUM_W'(1) == NUM_W'(k)) begin
        pair_d[k] = picked;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      valid_q <= 1'b0;
      odd_q   <= 1'b0;
      rem_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        n_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        valid_q <= req_ok;
        odd_q   <= n_q[0];
        rem_q   <= n_q;
      end else if (cmd_i.pick) begin
        odd_q <= 1'b0;
        rem_q <= rem_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q   <= index_i;
      total_q <= tot_full[TOTAL_W-1:0];
      slot_q  <= '0;
      q_q     <= '0;
      sub_q   <= n_q[0] ? dfact(n_q - NUM_W'(2)) : sub_of(n_q);
      for (int i = 0; i < LIST_LEN; i++) begin
        lst_q[i] <= NIB_W'(i);
      end
      for (int k = 0; k < PAIR_SLOTS; k++) begin
        pair_q[k] <= '0;
      end
    end else if (cmd_i.div_step) begin
      if (ge) begin
        idx_q              <= idx_q - shifted[IDX_W-1:0];
        q_q[cmd_i.div_bit] <= 1'b1;
      end
    end else if (cmd_i.pick) begin
      q_q   <= '0;
      sub_q <= sub_of(rem_n);
      if (!odd_q) begin
        slot_q <= slot_q + NUM_W'(2);
      end
      for (int i = 0; i < LIST_LEN; i++) begin
        lst_q[i] <= lst_d[i];
      end
      for (int k = 0; k < PAIR_SLOTS; k++) begin
        pair_q[k] <= pair_d[k];
      end
    end
  end

  assign status_o.ok   = valid_q;
  assign status_o.last = !odd_q && (rem_q < NUM_W'(4));

  always_comb begin
    for (int k = 0; k < PAIR_SLOTS; k++) begin
      pairing_o[k*NIB_W +: NIB_W] = pair_q[k];
    end
  end

  assign total_o     = total_q;
  assign valid_res_o = valid_q;

endmodule

[rtl/pairing_unranker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairing_unranker
// Returns the pairing of n_items elements at a requested rank, the number of
// pairings and a valid flag; one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result shows on
// pairing_o, total_o and valid_res_o in the single cycle in which done_o is
// high and must be captured then; it holds until the next request is taken.
// busy stays high from the cycle after the request until done_o is given.
// The number of index digits is n/2 for even n, (n+1)/2 for odd n, zero when
// the index is out of range. Each digit costs four restoring divide steps and
// one element pick. The user must write n_items through cfg_we_i only while
// busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pairing_unranker #(
  parameter int unsigned ITEM_LIMIT = pu_pkg::ITEM_LIMIT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pu_pkg::NUM_W-1:0]   cfg_wdata_i,
  input  logic                       start,
  output logic                       busy,
  input  logic [pu_pkg::IDX_W-1:0]   index_i,
  output logic                       done_o,
  output logic [pu_pkg::PAIR_W-1:0]  pairing_o,
  output logic [pu_pkg::TOTAL_W-1:0] total_o,
  output logic                       valid_res_o
);
  import pu_pkg::*;

  pu_cmd_t    cmd;
  pu_status_t status;

  pu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  pu_dpath #(
    .ITEM_LIMIT (ITEM_LIMIT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .index_i     (index_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .pairing_o   (pairing_o),
    .total_o     (total_o),
    .valid_res_o (valid_res_o)
  );

endmodule
